[rtl/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, constants and calendar helpers of the epoch calendar converter.
// ----------------------------------------------------------------------------
package ecc_pkg;

	localparam logic [31:0] SECS_MIN       = 32'd60;
	localparam logic [31:0] SECS_HOUR      = 32'd3600;
	localparam logic [31:0] SECS_DAY       = 32'd86400;
	localparam logic [31:0] SECS_YEAR      = 32'd31536000;
	localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;
	localparam logic [3:0]  MONTHS         = 4'd12;
	localparam logic [4:0]  FEB_DAYS       = 5'd28;
	localparam logic [2:0]  WD_EPOCH       = 3'd6;
	localparam logic [2:0]  DAYS_WEEK      = 3'd7;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ASM_YEAR,
		OP_ASM_MONTH,
		OP_ASM_DAY,
		OP_ASM_HOUR,
		OP_ASM_MIN,
		OP_ASM_SEC,
		OP_SPLIT_INIT,
		OP_SPLIT_YEAR,
		OP_SPLIT_MONTH,
		OP_SPLIT_DAY,
		OP_SPLIT_HOUR,
		OP_SPLIT_MIN
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic more;
	} sts_t;

	typedef struct packed {
		logic [31:0] total_seconds;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
	} res_t;

	// Gregorian rule on 2000 + y; within 2000..2255 only 2100 and 2200 are
	// century years that are not leap years.
	function automatic logic is_leap(input logic [7:0] y);
		return (y[1:0] == 2'b00) && (y != 8'd100) && (y != 8'd200);
	endfunction

	// Days of month index m (January is 0); indexes past December count zero.
	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd1: d = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

[rtl/ecc_dpath.sv]
// ----------------------------------------------------------------------------
// ecc_dpath
// Accumulator datapath: builds seconds from calendar fields one year or month
// per cycle, then takes them apart again by repeated compare and subtract.
// ----------------------------------------------------------------------------
module ecc_dpath (
	input  logic          clk,
	input  ecc_pkg::cmd_t cmd,
	input  logic          func,
	input  logic [31:0]   seconds_in,
	input  logic [7:0]    year_in,
	input  logic [3:0]    month_in,
	input  logic [4:0]    day_in,
	input  logic [4:0]    hour_in,
	input  logic [5:0]    minute_in,
	input  logic [5:0]    second_in,
	output ecc_pkg::sts_t sts,
	output ecc_pkg::res_t res
);

	logic        func_q;
	logic [7:0]  year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [31:0] acc_q;
	logic [31:0] total_q;
	logic [7:0]  cnt_q;
	logic [7:0]  yr_q;
	logic [3:0]  mo_q;
	logic [4:0]  dy_q;
	logic [4:0]  hr_q;
	logic [5:0]  mi_q;
	logic [2:0]  wd_q;

	logic        split_leap;
	logic [4:0]  asm_mdays;
	logic [4:0]  split_mdays;
	logic [4:0]  mdays_over;
	logic [31:0] day_m1;
	logic [31:0] add_val;
	logic [31:0] sub_len;
	logic [31:0] acc_sum;
	logic [31:0] acc_diff;
	logic        more;

	function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [1:0] k);
		logic [3:0] s;
		s = {1'b0, w} + {2'b00, k};
		if (s >= {1'b0, ecc_pkg::DAYS_WEEK}) begin
			s = s - {1'b0, ecc_pkg::DAYS_WEEK};
		end
		return s[2:0];
	endfunction

	assign split_leap  = ecc_pkg::is_leap(yr_q);
	assign asm_mdays   = ecc_pkg::days_in_month(mo_q, ecc_pkg::is_leap(year_q));
	assign split_mdays = ecc_pkg::days_in_month(mo_q, split_leap);
	assign mdays_over  = split_mdays - ecc_pkg::FEB_DAYS;
	// A day of zero wraps to one day before the first of the month.
	assign day_m1      = {27'd0, day_q} - 32'd1;

	always_comb begin
		case (cmd.op)
			ecc_pkg::OP_ASM_YEAR: add_val = ecc_pkg::is_leap(cnt_q) ?
				ecc_pkg::SECS_LEAP_YEAR : ecc_pkg::SECS_YEAR;
			ecc_pkg::OP_ASM_MONTH: add_val = {27'd0, asm_mdays} * ecc_pkg::SECS_DAY;
			ecc_pkg::OP_ASM_DAY:   add_val = day_m1 * ecc_pkg::SECS_DAY;
			ecc_pkg::OP_ASM_HOUR:  add_val = {27'd0, hour_q} * ecc_pkg::SECS_HOUR;
			ecc_pkg::OP_ASM_MIN:   add_val = {26'd0, minute_q} * ecc_pkg::SECS_MIN;
			ecc_pkg::OP_ASM_SEC:   add_val = {26'd0, second_q};
			default:               add_val = 32'd0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			ecc_pkg::OP_SPLIT_YEAR: sub_len = split_leap ?
				ecc_pkg::SECS_LEAP_YEAR : ecc_pkg::SECS_YEAR;
			ecc_pkg::OP_SPLIT_MONTH: sub_len = {27'd0, split_mdays} * ecc_pkg::SECS_DAY;
			ecc_pkg::OP_SPLIT_DAY:   sub_len = ecc_pkg::SECS_DAY;
			ecc_pkg::OP_SPLIT_HOUR:  sub_len = ecc_pkg::SECS_HOUR;
			ecc_pkg::OP_SPLIT_MIN:   sub_len = ecc_pkg::SECS_MIN;
			default:                 sub_len = 32'd0;
		endcase
	end

	assign acc_sum  = acc_q + add_val;
	assign acc_diff = acc_q - sub_len;

	always_comb begin
		case (cmd.op)
			ecc_pkg::OP_ASM_YEAR:    more = (cnt_q != year_q);
			ecc_pkg::OP_ASM_MONTH:   more = (({1'b0, mo_q} + 5'd1) < {1'b0, month_q});
			ecc_pkg::OP_SPLIT_MONTH: more = (mo_q < ecc_pkg::MONTHS) && (acc_q >= sub_len);
			ecc_pkg::OP_SPLIT_YEAR,
			ecc_pkg::OP_SPLIT_DAY,
			ecc_pkg::OP_SPLIT_HOUR,
			ecc_pkg::OP_SPLIT_MIN:   more = (acc_q >= sub_len);
			default:                 more = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ecc_pkg::OP_LOAD: begin
				func_q   <= func;
				year_q   <= year_in;
				month_q  <= month_in;
				day_q    <= day_in;
				hour_q   <= hour_in;
				minute_q <= minute_in;
				second_q <= second_in;
				acc_q    <= func ? 32'd0 : seconds_in;
				cnt_q    <= 8'd0;
				mo_q     <= 4'd0;
			end
			ecc_pkg::OP_ASM_YEAR: begin
				if (more) begin
					acc_q <= acc_sum;
					cnt_q <= cnt_q + 8'd1;
				end
			end
			ecc_pkg::OP_ASM_MONTH: begin
				if (more) begin
					acc_q <= acc_sum;
					mo_q  <= mo_q + 4'd1;
				end
			end
			ecc_pkg::OP_ASM_DAY,
			ecc_pkg::OP_ASM_HOUR,
			ecc_pkg::OP_ASM_MIN,
			ecc_pkg::OP_ASM_SEC: begin
				acc_q <= acc_sum;
			end
			ecc_pkg::OP_SPLIT_INIT: begin
				total_q <= acc_q;
				yr_q    <= 8'd0;
				mo_q    <= 4'd0;
				dy_q    <= 5'd0;
				hr_q    <= 5'd0;
				mi_q    <= 6'd0;
				wd_q    <= ecc_pkg::WD_EPOCH;
			end
			ecc_pkg::OP_SPLIT_YEAR: begin
				if (more) begin
					acc_q <= acc_diff;
					yr_q  <= yr_q + 8'd1;
					wd_q  <= wd_add(wd_q, split_leap ? 2'd2 : 2'd1);
				end
			end
			ecc_pkg::OP_SPLIT_MONTH: begin
				if (more) begin
					acc_q <= acc_diff;
					mo_q  <= mo_q + 4'd1;
					wd_q  <= wd_add(wd_q, mdays_over[1:0]);
				end
			end
			ecc_pkg::OP_SPLIT_DAY: begin
				if (more) begin
					acc_q <= acc_diff;
					dy_q  <= dy_q + 5'd1;
					wd_q  <= wd_add(wd_q, 2'd1);
				end
			end
			ecc_pkg::OP_SPLIT_HOUR: begin
				if (more) begin
					acc_q <= acc_diff;
					hr_q  <= hr_q + 5'd1;
				end
			end
			ecc_pkg::OP_SPLIT_MIN: begin
				if (more) begin
					acc_q <= acc_diff;
					mi_q  <= mi_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.func = func_q;
	assign sts.more = more;

	assign res.total_seconds = total_q;
	assign res.year          = yr_q;
	assign res.month         = mo_q + 4'd1;
	assign res.day           = dy_q + 5'd1;
	assign res.hour          = hr_q;
	assign res.minute        = mi_q;
	assign res.second        = acc_q[5:0];
	assign res.weekday       = wd_q + 3'd1;

endmodule

[rtl/ecc_ctrl.sv]
// ----------------------------------------------------------------------------
// ecc_ctrl
// Sequencer of the converter: steps the datapath through assembly and split
// phases and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module ecc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_free,
	input  ecc_pkg::sts_t sts,
	output ecc_pkg::cmd_t cmd,
	output logic          in_stall,
	output logic          out_load
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ASM_YEAR,
		S_ASM_MONTH,
		S_ASM_DAY,
		S_ASM_HOUR,
		S_ASM_MIN,
		S_ASM_SEC,
		S_SPLIT_INIT,
		S_SPLIT_YEAR,
		S_SPLIT_MONTH,
		S_SPLIT_DAY,
		S_SPLIT_HOUR,
		S_SPLIT_MIN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   in_stall_q;

	always_comb begin
		cmd.op    = ecc_pkg::OP_NONE;
		state_nxt = state_q;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op    = ecc_pkg::OP_LOAD;
					state_nxt = S_ASM_YEAR;
				end
			end
			S_ASM_YEAR: begin
				// A split request skips the whole assembly phase.
				if (!sts.func) begin
					state_nxt = S_SPLIT_INIT;
				end else begin
					cmd.op = ecc_pkg::OP_ASM_YEAR;
					if (!sts.more) state_nxt = S_ASM_MONTH;
				end
			end
			S_ASM_MONTH: begin
				cmd.op = ecc_pkg::OP_ASM_MONTH;
				if (!sts.more) state_nxt = S_ASM_DAY;
			end
			S_ASM_DAY: begin
				cmd.op    = ecc_pkg::OP_ASM_DAY;
				state_nxt = S_ASM_HOUR;
			end
			S_ASM_HOUR: begin
				cmd.op    = ecc_pkg::OP_ASM_HOUR;
				state_nxt = S_ASM_MIN;
			end
			S_ASM_MIN: begin
				cmd.op    = ecc_pkg::OP_ASM_MIN;
				state_nxt = S_ASM_SEC;
			end
			S_ASM_SEC: begin
				cmd.op    = ecc_pkg::OP_ASM_SEC;
				state_nxt = S_SPLIT_INIT;
			end
			S_SPLIT_INIT: begin
				cmd.op    = ecc_pkg::OP_SPLIT_INIT;
				state_nxt = S_SPLIT_YEAR;
			end
			S_SPLIT_YEAR: begin
				cmd.op = ecc_pkg::OP_SPLIT_YEAR;
				if (!sts.more) state_nxt = S_SPLIT_MONTH;
			end
			S_SPLIT_MONTH: begin
				cmd.op = ecc_pkg::OP_SPLIT_MONTH;
				if (!sts.more) state_nxt = S_SPLIT_DAY;
			end
			S_SPLIT_DAY: begin
				cmd.op = ecc_pkg::OP_SPLIT_DAY;
				if (!sts.more) state_nxt = S_SPLIT_HOUR;
			end
			S_SPLIT_HOUR: begin
				cmd.op = ecc_pkg::OP_SPLIT_HOUR;
				if (!sts.more) state_nxt = S_SPLIT_MIN;
			end
			S_SPLIT_MIN: begin
				cmd.op = ecc_pkg::OP_SPLIT_MIN;
				if (!sts.more) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			in_stall_q <= (state_nxt != S_IDLE);
		end
	end

	assign in_stall = in_stall_q;

endmodule

[rtl/epoch_calendar_converter_unit.sv]
// ----------------------------------------------------------------------------
// epoch_calendar_converter_unit
// Converts seconds since 2000-01-01 00:00:00 to calendar fields and back.
// A request enters on in_valid/in_stall; func 0 splits seconds_in, func 1
// assembles seconds from the calendar inputs and then splits that total so
// the weekday and normalized fields come out. One result leaves per request
// on out_valid/out_stall. The split steps through each whole year, month,
// day, hour and minute in the total; func 1 first steps through each year
// before year_in and each month before month_in, then adds the day, hour,
// minute and second fields. One request is in work at a time; in_stall is
// high from acceptance until the result moves into the output register,
// and the next request can be taken in the cycle after that. The output
// register can hold a result while the next request is taken. A stalled
// result holds its value until out_stall drops. Reset clears the controller
// and the output valid flag; nothing else needs clearing.
// ----------------------------------------------------------------------------
module epoch_calendar_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] seconds_in,
	input  logic [7:0]  year_in,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] total_seconds,
	output logic [7:0]  year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out,
	output logic [2:0]  weekday_out
);

	ecc_pkg::cmd_t cmd;
	ecc_pkg::sts_t sts;
	ecc_pkg::res_t res;
	ecc_pkg::res_t res_q;
	logic          out_valid_q;
	logic          out_free;
	logic          out_load;

	assign out_free = !out_valid_q || !out_stall;

	ecc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall),
		.out_load (out_load)
	);

	ecc_dpath u_dpath (
		.clk        (clk),
		.cmd        (cmd),
		.func       (func),
		.seconds_in (seconds_in),
		.year_in    (year_in),
		.month_in   (month_in),
		.day_in     (day_in),
		.hour_in    (hour_in),
		.minute_in  (minute_in),
		.second_in  (second_in),
		.sts        (sts),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign total_seconds = res_q.total_seconds;
	assign year_out      = res_q.year;
	assign month_out     = res_q.month;
	assign day_out       = res_q.day;
	assign hour_out      = res_q.hour;
	assign minute_out    = res_q.minute;
	assign second_out    = res_q.second;
	assign weekday_out   = res_q.weekday;

	// An accepted request keeps the block busy until its result is handed over.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but block not busy");

	// A result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_out >= 4'd1 && month_out <= 4'd12 &&
			day_out >= 5'd1 && weekday_out >= 3'd1 && weekday_out <= 3'd7 &&
			hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59))
		else $error("calendar field out of range");

endmodule
